// ----- hw/rtl/v3au_pkg.sv -----
// Package for the vector-3 arithmetic unit: word types, command codes and helpers.
package v3au_pkg;

   localparam int SqrtSteps = 32;
   localparam int QuoW      = 17;
   localparam int DivSteps  = QuoW;
   localparam int RemW      = 36;
   localparam int Latency   = 3 + SqrtSteps + DivSteps + 1;

   typedef enum logic [2:0] {
      CmdAdd       = 3'd0,
      CmdSub       = 3'd1,
      CmdScale     = 3'd2,
      CmdDot       = 3'd3,
      CmdCross     = 3'd4,
      CmdLength    = 3'd5,
      CmdNormalize = 3'd6
   } cmd_type;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusSat     = 2'd1;
   localparam logic [1:0] StatusZeroLen = 2'd2;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] scale_factor;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic [1:0]         status;
   } rsp_type;

   // Operands for one lane.
   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] add_a;
      logic signed [31:0] add_b;
      logic signed [31:0] mul0_a;
      logic signed [31:0] mul0_b;
      logic signed [31:0] mul1_a;
      logic signed [31:0] mul1_b;
   } lane_in_type;

   // Sideband that travels beside the square root and divider.
   typedef struct packed {
      logic [2:0]        command;
      logic [2:0][31:0]  r;
      logic              sat;
      logic [2:0][31:0]  mag;
      logic [2:0]        neg;
   } sb_type;

   typedef struct packed {
      logic [31:0] value;
      logic        flag;
   } sat_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type res;
      if (v > 64'sd2147483647) begin
         res.value = 32'h7FFF_FFFF;
         res.flag  = 1'b1;
      end else if (v < -64'sd2147483648) begin
         res.value = 32'h8000_0000;
         res.flag  = 1'b1;
      end else begin
         res.value = v[31:0];
         res.flag  = 1'b0;
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/v3au_lane.sv -----
// One arithmetic lane: two multipliers, an adder and the per-lane combine.
module v3au_lane (
   input  logic                      clock,
   input  v3au_pkg::lane_in_type     lane_in,
   output logic signed [63:0]        lane_val
);
   import v3au_pkg::*;

   logic signed [63:0] prod0_in, prod1_in, prod0_ff, prod1_ff;
   logic signed [32:0] sum_in, sum_ff;
   logic [2:0]         cmd_ff;
   logic signed [63:0] val_in, val_ff;
   logic signed [63:0] fl0, fl1;

   always_comb begin
      prod0_in = lane_in.mul0_a * lane_in.mul0_b;
      prod1_in = lane_in.mul1_a * lane_in.mul1_b;
      if (lane_in.command == CmdSub) begin
         sum_in = 33'(lane_in.add_a) - 33'(lane_in.add_b);
      end else begin
         sum_in = 33'(lane_in.add_a) + 33'(lane_in.add_b);
      end
   end

   always_ff @(posedge clock) begin
      prod0_ff <= prod0_in;
      prod1_ff <= prod1_in;
      sum_ff   <= sum_in;
      cmd_ff   <= lane_in.command;
   end

   // An arithmetic shift drops the fraction with rounding toward minus infinity.
   assign fl0 = prod0_ff >>> 16;
   assign fl1 = prod1_ff >>> 16;

   always_comb begin
      unique case (cmd_ff)
         CmdAdd, CmdSub:          val_in = 64'(sum_ff);
         CmdScale, CmdDot:        val_in = fl0;
         CmdCross:                val_in = fl0 - fl1;
         CmdLength, CmdNormalize: val_in = prod0_ff;
         default:                 val_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign lane_val = val_ff;
endmodule

// ----- hw/rtl/v3au_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module v3au_sqrt (
   input  logic        clock,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import v3au_pkg::*;

   logic [RemW-1:0] rem_ff  [SqrtSteps];
   logic [31:0]     root_ff [SqrtSteps];
   logic [63:0]     rad_ff  [SqrtSteps];

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
      logic [RemW-1:0] rem_prev, shifted, trial, rem_in;
      logic [31:0]     root_prev, root_in;
      logic [63:0]     rad_prev;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      always_comb begin
         shifted = {rem_prev[RemW-3:0], rad_prev[63:62]};
         trial   = RemW'({root_prev, 2'b01});
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_prev[30:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_prev[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= {rad_prev[61:0], 2'b00};
      end
   end

   assign root = root_ff[SqrtSteps-1];
endmodule

// ----- hw/rtl/v3au_div.sv -----
// Pipelined restoring divider for the normalize quotient, one bit per stage.
module v3au_div (
   input  logic            clock,
   input  logic [47:0]     num,
   input  logic [31:0]     den,
   output logic [16:0]     quo
);
   import v3au_pkg::*;

   logic [47:0]     rem_ff [DivSteps];
   logic [31:0]     den_ff [DivSteps];
   logic [QuoW-1:0] quo_ff [DivSteps];

   for (genvar s = 0; s < DivSteps; s++) begin : g_step
      localparam int J = QuoW - 1 - s;
      logic [47:0]     rem_prev, rem_in;
      logic [31:0]     den_prev;
      logic [QuoW-1:0] quo_prev, quo_in;
      logic [48:0]     dsub;

      if (s == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      always_comb begin
         dsub = 49'(den_prev) << J;
         if (49'(rem_prev) >= dsub) begin
            rem_in = 48'(49'(rem_prev) - dsub);
            quo_in = {quo_prev[QuoW-2:0], 1'b1};
         end else begin
            rem_in = rem_prev;
            quo_in = {quo_prev[QuoW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         den_ff[s] <= den_prev;
         quo_ff[s] <= quo_in;
      end
   end

   assign quo = quo_ff[DivSteps-1];
endmodule

// ----- hw/rtl/vec3_arithmetic_unit.sv -----
// Every word, whatever its command, passes through the full pipeline before its result appears.
// Throughput: one word per cycle; busy stays low, since every unit is fully pipelined.
// The depth is set by the 32-stage square root and the 17-stage normalize divider.
// The receiver cannot stall: rsp_valid marks each result for a single cycle.
// Reset (synchronous, active high) clears the valid pipeline and drops words in flight.
// Top level: three lanes, a merge stage, square root, dividers and the output register.
module vec3_arithmetic_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  v3au_pkg::req_type req_data,
   output logic              rsp_valid,
   output v3au_pkg::rsp_type rsp_data
);
   import v3au_pkg::*;

   logic signed [31:0] a [3];
   logic signed [31:0] b [3];
   lane_in_type        lane_in  [3];
   logic signed [63:0] lane_val [3];

   assign a[0] = req_data.a_x;
   assign a[1] = req_data.a_y;
   assign a[2] = req_data.a_z;
   assign b[0] = req_data.b_x;
   assign b[1] = req_data.b_y;
   assign b[2] = req_data.b_z;

   // The pipeline never holds a word back.
   assign busy = 1'b0;

   // Operand routing. Each lane owns one output component; for the cross product,
   // lane i forms the two products that make up component i.
   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      always_comb begin
         lane_in[i].command = req_data.command;
         lane_in[i].add_a   = a[i];
         lane_in[i].add_b   = b[i];
         lane_in[i].mul0_a  = a[i];
         lane_in[i].mul0_b  = b[i];
         lane_in[i].mul1_a  = '0;
         lane_in[i].mul1_b  = '0;
         case (req_data.command)
            CmdScale: lane_in[i].mul0_b = req_data.scale_factor;
            CmdCross: begin
               lane_in[i].mul0_a = a[J];
               lane_in[i].mul0_b = b[K];
               lane_in[i].mul1_a = a[K];
               lane_in[i].mul1_b = b[J];
            end
            CmdLength, CmdNormalize: lane_in[i].mul0_b = a[i];
            default: ;
         endcase
      end

      v3au_lane u_lane (
         .clock    (clock),
         .lane_in  (lane_in[i]),
         .lane_val (lane_val[i])
      );
   end

   // Sideband for the two lane stages: command, magnitudes and signs of a.
   sb_type sb_in, sb1_ff, sb2_ff;
   logic   v1_ff, v2_ff;

   always_comb begin
      sb_in         = '0;
      sb_in.command = req_data.command;
      for (int i = 0; i < 3; i++) begin
         sb_in.neg[i] = a[i][31];
         sb_in.mag[i] = a[i][31] ? (~a[i] + 32'd1) : a[i];
      end
   end

   always_ff @(posedge clock) begin
      sb1_ff <= sb_in;
      sb2_ff <= sb1_ff;
   end

   // Merge stage: dot sum, sum of squares and saturation of the vector results.
   sb_type             sbm_in, sbm_ff;
   logic [63:0]        sq_in, sq_ff;
   logic               vm_ff;
   logic signed [63:0] dot_sum;
   sat_type            sat_c [3];
   sat_type            sat_d;

   assign dot_sum = lane_val[0] + lane_val[1] + lane_val[2];
   assign sq_in   = 64'(lane_val[0]) + 64'(lane_val[1]) + 64'(lane_val[2]);
   assign sat_d   = sat32(dot_sum);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sat_c[i] = sat32(lane_val[i]);
      end
      sbm_in     = sb2_ff;
      sbm_in.r   = '0;
      sbm_in.sat = 1'b0;
      case (sb2_ff.command)
         CmdAdd, CmdSub, CmdScale, CmdCross: begin
            for (int i = 0; i < 3; i++) begin
               sbm_in.r[i] = sat_c[i].value;
            end
            sbm_in.sat = sat_c[0].flag | sat_c[1].flag | sat_c[2].flag;
         end
         CmdDot: begin
            sbm_in.r[0] = sat_d.value;
            sbm_in.sat  = sat_d.flag;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      sbm_ff <= sbm_in;
      sq_ff  <= sq_in;
   end

   // Square root of the sum of squares; the sideband waits beside it.
   logic [31:0]          root;
   sb_type               sb_sq_ff [SqrtSteps];
   logic [SqrtSteps-1:0] vsq_ff;

   v3au_sqrt u_sqrt (
      .clock    (clock),
      .radicand (sq_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      sb_sq_ff[0] <= sbm_ff;
      for (int k = 1; k < SqrtSteps; k++) begin
         sb_sq_ff[k] <= sb_sq_ff[k-1];
      end
   end

   // Normalize: each magnitude scaled by 2^16 and divided by the length.
   sb_type           sb_last;
   logic [QuoW-1:0]  quo [3];
   sb_type           sb_dv_ff   [DivSteps];
   logic [31:0]      root_dv_ff [DivSteps];
   logic [DivSteps-1:0] vdv_ff;

   assign sb_last = sb_sq_ff[SqrtSteps-1];

   for (genvar i = 0; i < 3; i++) begin : g_div
      v3au_div u_div (
         .clock (clock),
         .num   ({sb_last.mag[i], 16'h0000}),
         .den   (root),
         .quo   (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      sb_dv_ff[0]   <= sb_last;
      root_dv_ff[0] <= root;
      for (int k = 1; k < DivSteps; k++) begin
         sb_dv_ff[k]   <= sb_dv_ff[k-1];
         root_dv_ff[k] <= root_dv_ff[k-1];
      end
   end

   // Valid bits are the only state that reset clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         vm_ff     <= 1'b0;
         vsq_ff    <= '0;
         vdv_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         v1_ff     <= start & ~busy;
         v2_ff     <= v1_ff;
         vm_ff     <= v2_ff;
         vsq_ff    <= {vsq_ff[SqrtSteps-2:0], vm_ff};
         vdv_ff    <= {vdv_ff[DivSteps-2:0], vsq_ff[SqrtSteps-1]};
         rsp_valid <= vdv_ff[DivSteps-1];
      end
   end

   // Output select. Length and normalize take their values from the root and
   // quotients; every other command has its result ready from the merge stage.
   sb_type      sb_out;
   logic [31:0] len;
   rsp_type     rsp_in;

   assign sb_out = sb_dv_ff[DivSteps-1];
   assign len    = root_dv_ff[DivSteps-1];

   always_comb begin
      rsp_in     = '0;
      unique case (sb_out.command)
         CmdLength: begin
            rsp_in.r_x    = len[31] ? 32'h7FFF_FFFF : len;
            rsp_in.status = len[31] ? StatusSat : StatusOk;
         end
         CmdNormalize: begin
            if (len == '0) begin
               rsp_in.status = StatusZeroLen;
            end else begin
               rsp_in.r_x = sb_out.neg[0] ? -32'(quo[0]) : 32'(quo[0]);
               rsp_in.r_y = sb_out.neg[1] ? -32'(quo[1]) : 32'(quo[1]);
               rsp_in.r_z = sb_out.neg[2] ? -32'(quo[2]) : 32'(quo[2]);
            end
         end
         default: begin
            rsp_in.r_x    = sb_out.r[0];
            rsp_in.r_y    = sb_out.r[1];
            rsp_in.r_z    = sb_out.r[2];
            rsp_in.status = sb_out.sat ? StatusSat : StatusOk;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data <= rsp_in;
   end
endmodule

// ----- hw/rtl/v3au_checker.sv -----
// Port checker for the vector-3 arithmetic unit, bound to the top level.
module v3au_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input v3au_pkg::req_type req_data,
   input logic              rsp_valid,
   input v3au_pkg::rsp_type rsp_data
);
   import v3au_pkg::*;

   // Every accepted word gives its result after the fixed pipeline depth.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_valid)
      else $error("result missing after accepted word");

   // No result appears without a word accepted at the matching earlier cycle.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without a matching word");

   // A zero-length normalize reports all components as zero.
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == StatusZeroLen) |->
         (rsp_data.r_x == '0 && rsp_data.r_y == '0 && rsp_data.r_z == '0))
      else $error("zero-length result with nonzero components");

   // Status never carries the unused code.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == StatusOk || rsp_data.status == StatusSat ||
                     rsp_data.status == StatusZeroLen))
      else $error("invalid status code");
endmodule

bind vec3_arithmetic_unit v3au_checker u_checker (.*);
